// ----- rtl/core/qph_pkg.sv -----
// types and constants shared by the quadratic probe hash table
package qph_pkg;

    localparam int KEY_W          = 32;
    localparam int SLOT_W         = 4;
    localparam int HASH_CYCLES    = 3;
    localparam int HASH_CNT_W     = $clog2(HASH_CYCLES);

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_ERASE  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic load;
        logic hash;
        logic rd;
        logic check;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic req_valid;
        logic clr_last;
        logic hash_last;
        logic hit;
        logic path_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/core/qph_req_if.sv -----
// request channel: action and key
interface qph_req_if;
    logic                          valid;
    logic                          ready;
    qph_pkg::t_action              action;
    logic [qph_pkg::KEY_W-1:0]     key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

// ----- rtl/core/qph_rsp_if.sv -----
// response channel: status and slot
interface qph_rsp_if;
    logic                          valid;
    logic                          ready;
    qph_pkg::t_status              status;
    logic [qph_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

// ----- rtl/core/qph_ctrl.sv -----
// controller state machine for the hash table
module qph_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qph_pkg::t_dp_stat  i_stat,
    output qph_pkg::t_dp_cmd   o_cmd
);
    import qph_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.hit || i_stat.path_end) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- rtl/core/qph_dpath.sv -----
// datapath: slot memory, home slot remainder, probe walk and response register
module qph_dpath #(
    parameter int TABLE_SIZE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qph_pkg::t_dp_cmd   i_cmd,
    output qph_pkg::t_dp_stat  o_stat,
    qph_req_if.sink            i_req,
    qph_rsp_if.source          o_rsp
);
    import qph_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int SH = KEY_W + AW;
    localparam logic [32:0] RECIP =
        33'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam logic [15:0]   RCP_LO = RECIP[15:0];
    localparam logic [16:0]   RCP_HI = RECIP[32:16];
    localparam logic [AW-1:0] T_LOW  = AW'(TABLE_SIZE);
    localparam logic [AW+1:0] T_END  = (AW+2)'(TABLE_SIZE);
    localparam logic [AW-1:0] T_LAST = AW'(TABLE_SIZE - 1);

    logic [KEY_W-1:0]       r_mem [TABLE_SIZE];
    logic [KEY_W-1:0]       r_rd_data;

    logic [AW-1:0]          r_clr_idx;
    t_action                r_act;
    logic [KEY_W-1:0]       r_key;
    logic [HASH_CNT_W-1:0]  r_hash_cnt;
    logic [47:0]            r_prod_lo;
    logic [48:0]            r_prod_hi;
    logic [AW-1:0]          r_quo_lo;
    logic [AW-1:0]          r_idx;
    logic [AW:0]            r_step;

    t_status                r_res_status;
    logic [SLOT_W-1:0]      r_res_slot;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;

    logic [64:0]            prod_sum;
    logic [AW-1:0]          quo_prod;
    logic [AW-1:0]          n_rem;
    logic [AW+1:0]          n_sum;
    logic [KEY_W-1:0]       target;
    logic                   hit;
    logic                   do_wr;
    logic [AW-1:0]          wr_addr;
    logic [KEY_W-1:0]       wr_data;

    // home slot by reciprocal multiply, low bits of the quotient only
    assign prod_sum = 65'(r_prod_lo) + {r_prod_hi, 16'b0};
    assign quo_prod = r_quo_lo * T_LOW;
    assign n_rem    = r_key[AW-1:0] - quo_prod;

    assign target = (r_act == ACT_INSERT) ? EMPTY_KEY : r_key;
    assign hit    = (r_rd_data == target);
    assign n_sum  = (AW+2)'(r_idx) + (AW+2)'(r_step);

    always_comb begin
        if (i_cmd.clr_wr) begin
            do_wr   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = EMPTY_KEY;
        end else begin
            do_wr   = i_cmd.check && hit && (r_act == ACT_INSERT || r_act == ACT_ERASE);
            wr_addr = r_idx;
            wr_data = (r_act == ACT_INSERT) ? r_key : EMPTY_KEY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_req.action;
            r_key      <= i_req.key;
            r_hash_cnt <= '0;
        end
        if (i_cmd.hash) begin
            r_prod_lo  <= 48'(r_key) * 48'(RCP_LO);
            r_prod_hi  <= 49'(r_key) * 49'(RCP_HI);
            r_quo_lo   <= prod_sum[SH+AW-1:SH];
            r_hash_cnt <= r_hash_cnt + HASH_CNT_W'(1);
            if (o_stat.hash_last) begin
                r_idx  <= n_rem;
                r_step <= (AW+1)'(1);
            end
        end
        if (i_cmd.check) begin
            if (hit) begin
                r_res_status <= ST_OK;
                r_res_slot   <= SLOT_W'(r_idx);
            end else if (o_stat.path_end) begin
                r_res_status <= (r_act == ACT_INSERT) ? ST_NO_SPACE : ST_NOT_FOUND;
                r_res_slot   <= '0;
            end else begin
                r_idx  <= n_sum[AW-1:0];
                r_step <= r_step + (AW+1)'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    assign i_req.ready  = i_cmd.in_ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    assign o_stat.req_valid = i_req.valid;
    assign o_stat.clr_last  = (r_clr_idx == T_LAST);
    assign o_stat.hash_last = (r_hash_cnt == HASH_CNT_W'(HASH_CYCLES - 1));
    assign o_stat.hit       = hit;
    assign o_stat.path_end  = (n_sum >= T_END);
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

endmodule

// ----- rtl/core/quadratic_probe_hash_table.sv -----
// top level of the quadratic probe hash table
//
// requests arrive on i_req (action, key) and results leave on o_rsp
// (status, slot), both valid/ready; a request is taken when valid and
// ready are high at a clock edge. one result per request, in order
// after reset a clearing pass writes empty into every slot, one per
// cycle; i_req.ready stays low until it ends
// one request at a time: accept, home slot remainder (reciprocal
// multiply), then per probe a memory read and a compare with optional
// write, then a load of the response register
// the next request is taken only after the result is loaded into the
// response register; probes range from 1 to about sqrt(TABLE_SIZE),
// one slot read each
// the response register frees the core while the result waits; if
// o_rsp stalls, the next request still runs and holds in the core
// until the response register can take it
module quadratic_probe_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qph_req_if.sink     i_req,
    qph_rsp_if.source   o_rsp
);
    import qph_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    qph_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- bench/tb_quadratic_probe_hash_table.sv -----
// testbench for the quadratic probe hash table, checked against a slot mirror
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;
    import qph_pkg::*;

    localparam int          TABLE_SIZE     = 16;
    localparam logic [1:0]  ACT_SPARE      = 2'd3;
    localparam int          IDLE_PCT       = 28;
    localparam int          DRAIN_CYCLES   = 24;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          POOL_SIZE      = 8;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qph_req_if req_if ();
    qph_rsp_if rsp_if ();

    quadratic_probe_hash_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [KEY_W-1:0]   slot_mirror [TABLE_SIZE];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    t_rsp_item          expected_rsp [$];
    bit                 idle_on = 1'b1;
    int                 hold_left = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        fail_count = 0;
    int unsigned        req_count = 0;
    int unsigned        rsp_count = 0;
    int unsigned        miss_count = 0;
    int unsigned        action_count [4] = '{0, 0, 0, 0};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_rsp_item probe_predict(input logic [1:0] act,
                                                input logic [KEY_W-1:0] key);
        int unsigned        home;
        int unsigned        idx;
        int unsigned        n;
        logic [KEY_W-1:0]   target;
        bit                 hit;
        t_rsp_item          r;
        home   = key % TABLE_SIZE;
        idx    = home;
        n      = 0;
        hit    = 1'b0;
        target = (act == ACT_INSERT) ? EMPTY_KEY : key;
        while (!hit && idx < TABLE_SIZE) begin
            if (slot_mirror[idx] == target) begin
                hit = 1'b1;
            end else begin
                n++;
                idx = home + n * n;
            end
        end
        if (hit) begin
            if (act == ACT_INSERT)
                slot_mirror[idx] = key;
            else if (act == ACT_ERASE)
                slot_mirror[idx] = EMPTY_KEY;
            r.status = ST_OK;
            r.slot   = idx[SLOT_W-1:0];
        end else begin
            r.status = (act == ACT_INSERT) ? ST_NO_SPACE : ST_NOT_FOUND;
            r.slot   = '0;
        end
        return r;
    endfunction

    // request and result monitor with watchdog
    always @(posedge i_clk) begin
        t_rsp_item exp_rsp;
        if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
                $error("unexpected result: status %0d slot %0d", rsp_if.status, rsp_if.slot);
                fail_count++;
            end else begin
                exp_rsp = expected_rsp.pop_front();
                if (rsp_if.status !== exp_rsp.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_rsp.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.slot !== exp_rsp.slot) begin
                    $error("slot mismatch: expected %0d, actual %0d",
                           exp_rsp.slot, rsp_if.slot);
                    fail_count++;
                end
            end
        end
        if (req_if.valid && req_if.ready) begin
            req_count++;
            action_count[req_if.action]++;
            exp_rsp = probe_predict(req_if.action, req_if.key);
            if (exp_rsp.status != ST_OK)
                miss_count++;
            expected_rsp.push_back(exp_rsp);
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result for %0d cycles", quiet_cycles);
            $display("FAIL quadratic_probe_hash_table");
            $finish;
        end
    end

    // result receiver
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [KEY_W-1:0] key);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid  <= 1'b1;
        req_if.action <= t_action'(act);
        req_if.key    <= key;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic refresh_pool_entry(input int i);
        int unsigned home;
        home = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        key_pool[i] = ($urandom() & 32'hFFFF_FFF0) | home;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    task automatic run_random_ops(input int count, input int ins_pct, input int era_pct,
                                  input int refresh_every);
        int         r;
        logic [1:0] act;
        for (int i = 0; i < count; i++) begin
            if (refresh_every > 0 && i % refresh_every == refresh_every - 1)
                refresh_pool_entry($urandom_range(0, POOL_SIZE - 1));
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                act = ACT_INSERT;
            else if (r < ins_pct + era_pct)
                act = ACT_ERASE;
            else if (r < 96)
                act = ACT_FIND;
            else
                act = ACT_SPARE;
            send_request(act, pick_key());
        end
    endtask

    task automatic test_directed_paths();
        send_request(ACT_FIND,   32'd0);
        send_request(ACT_ERASE,  32'd5);
        send_request(ACT_INSERT, 32'd0);
        send_request(ACT_INSERT, 32'd16);
        send_request(ACT_INSERT, 32'd32);
        send_request(ACT_INSERT, 32'd48);
        send_request(ACT_INSERT, 32'd64);
        send_request(ACT_FIND,   32'd48);
        send_request(ACT_SPARE,  32'd32);
        send_request(ACT_ERASE,  32'd16);
        send_request(ACT_FIND,   32'd48);
        send_request(ACT_INSERT, 32'd80);
        send_request(ACT_SPARE,  32'h1234_5670);
        send_request(ACT_INSERT, EMPTY_KEY);
        send_request(ACT_FIND,   EMPTY_KEY);
        send_request(ACT_ERASE,  EMPTY_KEY);
        send_request(ACT_INSERT, 32'hFFFF_FFFE);
        send_request(ACT_FIND,   32'hFFFF_FFFE);
        send_request(ACT_ERASE,  32'hFFFF_FFFE);
        send_request(ACT_INSERT, 32'd15);
        send_request(ACT_INSERT, 32'd31);
        send_request(ACT_FIND,   EMPTY_KEY);
        send_request(ACT_ERASE,  32'h8000_000F);
        wait_for_results();
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < POOL_SIZE; i++)
            refresh_pool_entry(i);
        run_random_ops(250, 55, 15, 50);
        run_random_ops(300, 35, 35, 40);
        run_random_ops(250, 15, 55, 50);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_random_ops(350, 40, 30, 60);
        wait_for_results();
        idle_on = 1'b1;
    endtask

    task automatic test_response_stall();
        hold_left = HOLD_CYCLES;
        run_random_ops(16, 40, 30, 0);
        wait_for_results();
    endtask

    task automatic test_key_churn();
        for (int i = 0; i < POOL_SIZE; i++)
            refresh_pool_entry(i);
        run_random_ops(360, 40, 40, 12);
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++)
            slot_mirror[i] = EMPTY_KEY;
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.action <= ACT_INSERT;
        req_if.key    <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_paths();
        test_random_mix();
        test_back_to_back();
        test_response_stall();
        test_key_churn();

        $display("covered %0d requests and %0d results, %0d of them misses or full paths",
                 req_count, rsp_count, miss_count);
        $display("insert %0d, find %0d, erase %0d, unused code %0d, incl. a long result stall",
                 action_count[0], action_count[1], action_count[2], action_count[3]);
        if (fail_count == 0)
            $display("PASS quadratic_probe_hash_table");
        else
            $display("FAIL quadratic_probe_hash_table");
        $finish;
    end

endmodule
